// ----- sv/ievf_pkg.sv -----
// shared types and constants for the input event fifo with time words
// no dependencies
package ievf_pkg;

    localparam int WORD_W    = 16;
    localparam int TIME_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int STORED_W  = 2;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STORED_W-1:0] stored_t;

    localparam action_t ACT_PUSH = 2'd0;
    localparam action_t ACT_TICK = 2'd1;
    localparam action_t ACT_POP  = 2'd2;

    // largest gap that still fits in a delta-time word
    localparam time_t DELTA_LIMIT   = 32'd4095;
    localparam word_t ABS_TIME_CODE = 16'h5000;

    localparam stored_t STORED_ONE   = 2'd1;
    localparam stored_t STORED_TWO   = 2'd2;
    localparam stored_t STORED_THREE = 2'd3;

endpackage

// ----- sv/ievf_ram.sv -----
// single-port event word store, registered read data
// depends on ievf_pkg for the word type
module ievf_ram
    import ievf_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  word_t             wdata,
    output word_t             rdata
);

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/input_event_fifo_with_time_words_unit.sv -----
// input event ring buffer with time words, one slot always kept free
// a push, a pop or a short tick runs in ST_EXEC, a tick that stores the three
// absolute-time words also in ST_LOW and ST_HIGH (one write per cycle on the single store port)
// a new beat is taken only in ST_IDLE, after the result has moved on from ST_OUT,
// where the output register waits on m_tready before it can take the next result
// reset (aresetn low, synchronous): pointers, last tick and enable cleared, store kept
module input_event_fifo_with_time_words_unit
    import ievf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: events_enabled
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // [15:0] event_word, [47:16] time_ms
    input  logic [1:0]  s_tuser,  // [1:0] action
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [15:0] read_word, [17:16] words_stored, [18] queue_empty
    output logic        m_tuser   // [0] read_was_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM3_CNT  = CNT_W'(QUEUE_DEPTH - 3);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_LOW  = 3'd2;
    localparam logic [2:0] ST_HIGH = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    time_t            last_tick_reg, last_tick_next;
    logic             enabled_reg;

    action_t          in_action_reg;
    word_t            in_word_reg;
    time_t            in_time_reg;

    word_t            res_word_reg, res_word_next;
    logic             res_empty_reg, res_empty_next;
    stored_t          res_stored_reg, res_stored_next;
    logic             res_from_ram_reg, res_from_ram_next;

    logic             m_valid_reg, m_valid_next;
    word_t            m_word_reg, m_word_next;
    logic             m_empty_flag_reg, m_empty_flag_next;
    stored_t          m_stored_reg, m_stored_next;
    logic             m_qempty_reg, m_qempty_next;

    logic             ram_en, ram_we;
    logic [PTR_W-1:0] ram_addr;
    word_t            ram_wdata, ram_rdata;

    logic [CNT_W-1:0] used;
    logic             full, room3, qempty;
    time_t            gap;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;

    ievf_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // occupancy of the ring, pointers wrap at QUEUE_DEPTH
    always_comb begin
        if (wr_ptr_reg >= rd_ptr_reg) begin
            used = CNT_W'(wr_ptr_reg) - CNT_W'(rd_ptr_reg);
        end else begin
            used = CNT_W'(wr_ptr_reg) + DEPTH_CNT - CNT_W'(rd_ptr_reg);
        end
    end

    assign full       = (used >= FULL_CNT);
    assign room3      = (used < ROOM3_CNT);
    assign qempty     = (rd_ptr_reg == wr_ptr_reg);
    assign gap        = in_time_reg - last_tick_reg;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        state_next        = state_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        last_tick_next    = last_tick_reg;
        res_word_next     = res_word_reg;
        res_empty_next    = res_empty_reg;
        res_stored_next   = res_stored_reg;
        res_from_ram_next = res_from_ram_reg;
        m_valid_next      = m_valid_reg & ~m_tready;
        m_word_next       = m_word_reg;
        m_empty_flag_next = m_empty_flag_reg;
        m_stored_next     = m_stored_reg;
        m_qempty_next     = m_qempty_reg;
        ram_en            = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = wr_ptr_reg;
        ram_wdata         = in_word_reg;
        s_tready          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_word_next     = '0;
                res_empty_next    = 1'b0;
                res_stored_next   = '0;
                res_from_ram_next = 1'b0;
                state_next        = ST_OUT;
                case (in_action_reg)
                    ACT_PUSH: begin
                        if (enabled_reg && !full) begin
                            ram_en          = 1'b1;
                            ram_we          = 1'b1;
                            wr_ptr_next     = wr_ptr_inc;
                            res_stored_next = STORED_ONE;
                        end
                    end
                    ACT_TICK: begin
                        last_tick_next = in_time_reg;
                        if (gap <= DELTA_LIMIT) begin
                            if (enabled_reg && !full) begin
                                ram_en          = 1'b1;
                                ram_we          = 1'b1;
                                ram_wdata       = gap[WORD_W-1:0];
                                wr_ptr_next     = wr_ptr_inc;
                                res_stored_next = STORED_ONE;
                            end
                        end else if (enabled_reg && room3) begin
                            ram_en          = 1'b1;
                            ram_we          = 1'b1;
                            ram_wdata       = ABS_TIME_CODE;
                            wr_ptr_next     = wr_ptr_inc;
                            res_stored_next = STORED_ONE;
                            state_next      = ST_LOW;
                        end
                    end
                    ACT_POP: begin
                        if (qempty) begin
                            res_empty_next = 1'b1;
                        end else begin
                            ram_en            = 1'b1;
                            ram_addr          = rd_ptr_reg;
                            rd_ptr_next       = rd_ptr_inc;
                            res_from_ram_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_LOW: begin
                ram_en          = 1'b1;
                ram_we          = 1'b1;
                ram_wdata       = in_time_reg[WORD_W-1:0];
                wr_ptr_next     = wr_ptr_inc;
                res_stored_next = STORED_TWO;
                state_next      = ST_HIGH;
            end
            ST_HIGH: begin
                ram_en          = 1'b1;
                ram_we          = 1'b1;
                ram_wdata       = in_time_reg[TIME_W-1:WORD_W];
                wr_ptr_next     = wr_ptr_inc;
                res_stored_next = STORED_THREE;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next      = 1'b1;
                    m_word_next       = res_from_ram_reg ? ram_rdata : res_word_reg;
                    m_empty_flag_next = res_empty_reg;
                    m_stored_next     = res_stored_reg;
                    m_qempty_next     = qempty;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            last_tick_reg <= '0;
            enabled_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            last_tick_reg <= last_tick_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                enabled_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_word_reg   <= s_tdata[WORD_W-1:0];
            in_time_reg   <= s_tdata[WORD_W+TIME_W-1:WORD_W];
        end
        res_word_reg     <= res_word_next;
        res_empty_reg    <= res_empty_next;
        res_stored_reg   <= res_stored_next;
        res_from_ram_reg <= res_from_ram_next;
        m_word_reg       <= m_word_next;
        m_empty_flag_reg <= m_empty_flag_next;
        m_stored_reg     <= m_stored_next;
        m_qempty_reg     <= m_qempty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_qempty_reg, m_stored_reg, m_word_reg};
    assign m_tuser  = m_empty_flag_reg;

endmodule

// ----- sim/tb_input_event_fifo_with_time_words_unit.sv -----
// testbench for input_event_fifo_with_time_words_unit: directed and random event beats,
// results checked against a ring buffer predictor kept alongside the stimulus
// depends on ievf_pkg and the unit itself
`timescale 1ns / 1ps

module tb_input_event_fifo_with_time_words_unit;
    import ievf_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int CYCLE_LIMIT = 800000;
    localparam action_t ACT_NOP = 2'd3;

    typedef struct packed {
        action_t act;
        word_t   word;
        time_t   ms;
    } fifo_beat_t;

    typedef struct packed {
        word_t   read_word;
        logic    was_empty;
        stored_t stored;
        logic    empty;
    } readout_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // [15:0] event_word, [47:16] time_ms
    logic [1:0]  s_tuser = '0;  // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // [15:0] read_word, [17:16] words_stored, [18] queue_empty
    logic        m_tuser;       // [0] read_was_empty

    input_event_fifo_with_time_words_unit #(
        .QUEUE_DEPTH(RING_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor state
    word_t ring [RING_DEPTH];
    int    rd_ptr = 0;
    int    wr_ptr = 0;
    time_t last_tick = '0;
    logic  events_on = 1'b0;

    fifo_beat_t cmd_backlog[$];
    readout_t   expected_readouts[$];
    fifo_beat_t cur_beat;
    time_t      tick_clock = '0;
    int         in_gap = 0;
    int         out_hold = 0;
    bit         no_idle = 0;
    int         err_count = 0;
    int         cycles = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int ring_used();
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    function automatic stored_t ring_push(input word_t w);
        if (!events_on || ring_used() >= RING_DEPTH - 1)
            return '0;
        ring[wr_ptr] = w;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        return STORED_ONE;
    endfunction

    function automatic readout_t step_ring(input fifo_beat_t b);
        readout_t r;
        time_t    gap;
        r = '0;
        case (b.act)
            ACT_PUSH: r.stored = ring_push(b.word);
            ACT_TICK: begin
                gap = b.ms - last_tick;
                last_tick = b.ms;
                if (gap <= DELTA_LIMIT) begin
                    r.stored = ring_push(gap[15:0]);
                end else if (ring_used() < RING_DEPTH - 3) begin
                    r.stored = ring_push(ABS_TIME_CODE);
                    r.stored += ring_push(b.ms[15:0]);
                    r.stored += ring_push(b.ms[31:16]);
                end
            end
            ACT_POP: begin
                if (rd_ptr == wr_ptr) begin
                    r.was_empty = 1'b1;
                end else begin
                    r.read_word = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                end
            end
            default: ;
        endcase
        r.empty = (rd_ptr == wr_ptr);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic add_beat(input action_t act, input word_t w, input time_t ms);
        cmd_backlog.push_back('{act: act, word: w, ms: ms});
    endtask

    task automatic queue_random(input int n, input int push_pct, input int tick_pct,
                                input int pop_pct);
        int    r;
        int    k;
        time_t step;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                add_beat(ACT_PUSH, word_t'($urandom()), time_t'($urandom()));
            end else if (r < push_pct + tick_pct) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    step = $urandom_range(0, 4095);
                else if (r < 60)
                    step = $urandom_range(0, 1) ? 32'd4095 : 32'd4096;
                else if (r < 80)
                    step = $urandom_range(4096, 1 << 20);
                else
                    step = $urandom();  // anything, wrapping back too
                tick_clock = tick_clock + step;
                add_beat(ACT_TICK, word_t'($urandom()), tick_clock);
            end else if (r < push_pct + tick_pct + pop_pct) begin
                add_beat(ACT_POP, word_t'($urandom()), time_t'($urandom()));
            end else begin
                add_beat(ACT_NOP, word_t'($urandom()), time_t'($urandom()));
            end
        end
    endtask

    task automatic drain_all();
        while (cmd_backlog.size() != 0 || s_tvalid || expected_readouts.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_enable(input logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        events_on = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_readouts.push_back(step_ring(cur_beat));
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cur_beat = cmd_backlog.pop_front();
                    s_tdata <= {cur_beat.ms, cur_beat.word};
                    s_tuser <= cur_beat.act;
                    s_tvalid <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        readout_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_readouts.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = expected_readouts.pop_front();
                    if (m_tdata[15:0] !== want.read_word) begin
                        $error("read_word: expected %h, got %h", want.read_word, m_tdata[15:0]);
                        err_count++;
                    end
                    if (m_tuser !== want.was_empty) begin
                        $error("read_was_empty: expected %b, got %b", want.was_empty, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[17:16] !== want.stored) begin
                        $error("words_stored: expected %0d, got %0d", want.stored,
                               m_tdata[17:16]);
                        err_count++;
                    end
                    if (m_tdata[18] !== want.empty) begin
                        $error("queue_empty: expected %b, got %b", want.empty, m_tdata[18]);
                        err_count++;
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                out_hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_input_event_fifo_with_time_words_unit: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // pushes off: nothing stored, tick still moves the last time value
        write_enable(1'b0);
        add_beat(ACT_TICK, '0, 32'h1234_5678);
        add_beat(ACT_PUSH, 16'hBEEF, '0);
        add_beat(ACT_POP, '0, '0);
        add_beat(ACT_NOP, '0, '0);
        drain_all();

        write_enable(1'b1);
        add_beat(ACT_TICK, '0, 32'h1234_5678);          // zero gap
        add_beat(ACT_TICK, '0, 32'h1234_5678 + 4095);   // largest delta
        add_beat(ACT_TICK, '0, 32'h1234_5678 + 8191);   // one past, absolute words
        add_beat(ACT_TICK, '0, 32'hFFFF_FFFF);
        add_beat(ACT_TICK, '0, 32'h0000_0005);          // wraps to a small gap
        add_beat(ACT_PUSH, 16'h0000, '0);
        add_beat(ACT_PUSH, 16'hFFFF, '0);
        add_beat(ACT_NOP, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (12) add_beat(ACT_POP, '0, '0);          // last one finds it empty
        tick_clock = 32'h0000_0005;
        drain_all();

        // fill until full and stay there, then drain past empty
        queue_random(500, 60, 25, 12);
        drain_all();
        queue_random(400, 15, 10, 73);
        drain_all();

        write_enable(1'b0);
        queue_random(150, 35, 30, 30);
        drain_all();

        write_enable(1'b1);
        no_idle = 1;
        queue_random(400, 30, 28, 40);
        drain_all();
        no_idle = 0;
        queue_random(250, 62, 28, 8);
        queue_random(250, 12, 12, 74);
        drain_all();

        if (err_count == 0)
            $display("tb_input_event_fifo_with_time_words_unit: done, clean");
        else
            $display("tb_input_event_fifo_with_time_words_unit: done, errors");
        $finish;
    end

endmodule

// ----- input_event_fifo_with_time_words_unit.f -----
sv/ievf_pkg.sv
sv/ievf_ram.sv
sv/input_event_fifo_with_time_words_unit.sv
sim/tb_input_event_fifo_with_time_words_unit.sv
